[src/frs_pkg.sv]
`default_nettype none
package frs_pkg;

    localparam int NUM_BANKS_DEF     = 16;
    localparam int READ_ENTRIES_DEF  = 64;
    localparam int WRITE_ENTRIES_DEF = 64;
    localparam int ROW_BITS_DEF      = 16;
    localparam int TAG_BITS_DEF      = 16;

    localparam int BANK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int PEND_W     = 7;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ENQUEUE  = 1'b0,
        CMD_SCHEDULE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_SEPARATE = 3'd0,
        CFG_HIGH_WATERMARK = 3'd1,
        CFG_LOW_WATERMARK  = 3'd2,
        CFG_READ_LIMIT     = 3'd3,
        CFG_WRITE_LIMIT    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PASS_PICK_ROW,
        PASS_FIND_OLDEST,
        PASS_REORDER
    } pass_t;

endpackage
`default_nettype wire

[src/frs_if.sv]
`default_nettype none
interface frs_req_if #(
    parameter int ROW_BITS = frs_pkg::ROW_BITS_DEF,
    parameter int TAG_BITS = frs_pkg::TAG_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [frs_pkg::BANK_W-1:0] bank;
    logic [ROW_BITS-1:0]       row;
    logic                      wr_req;
    logic [TAG_BITS-1:0]       req_tag;
    logic [ROW_BITS-1:0]       open_row;

    modport source (output valid, cmd, bank, row, wr_req, req_tag, open_row, input ready);
    modport sink   (input valid, cmd, bank, row, wr_req, req_tag, open_row, output ready);
endinterface

interface frs_rsp_if #(
    parameter int ROW_BITS = frs_pkg::ROW_BITS_DEF,
    parameter int TAG_BITS = frs_pkg::TAG_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [TAG_BITS-1:0]        grant_tag;
    logic [ROW_BITS-1:0]        grant_row;
    logic                       grant_wr;
    logic                       row_hit;
    logic [1:0]                 status;
    logic [frs_pkg::PEND_W-1:0] reads_pending;
    logic [frs_pkg::PEND_W-1:0] writes_pending;
    logic                       wr_drain;

    modport source (output valid, granted, grant_tag, grant_row, grant_wr, row_hit,
                    status, reads_pending, writes_pending, wr_drain, input ready);
    modport sink   (input valid, granted, grant_tag, grant_row, grant_wr, row_hit,
                    status, reads_pending, writes_pending, wr_drain, output ready);
endinterface

interface frs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [frs_pkg::CFG_IDX_W-1:0]  index;
    logic [frs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/frs_pool.sv]
`default_nettype none
module frs_pool #(
    parameter int ENTRIES = frs_pkg::READ_ENTRIES_DEF,
    parameter int DATA_W  = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic      [DATA_W-1:0]          rd_data,
    output logic                            rd_valid,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       set_en,
    input  wire logic                       clr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] valid_addr,
    output logic                            free_found,
    output logic      [$clog2(ENTRIES)-1:0] free_idx
);
    localparam int IW = $clog2(ENTRIES);

    logic [DATA_W-1:0]  mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (set_en)
            begin
                valid_reg[valid_addr] <= 1'b1;
            end
            else if (clr_en)
            begin
                valid_reg[valid_addr] <= 1'b0;
            end
        end
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;
endmodule
`default_nettype wire

[src/frfcfs_dram_request_scheduler_top.sv]
`default_nettype none
// Per-bank FR-FCFS request queue. An enqueue item stores a request in the read pool or,
// when the separate write pool is enabled, a write in the write pool. A schedule item
// sweeps the selected pool memory one entry per cycle: one sweep to pick the active row
// when the bank has none, one to find the oldest request of that row, and one to renumber
// the ages after removal. The sweep rate is set by the single read port of the pool
// memory. One result per item is returned through an output register; the user must see
// that configuration is written only while the block is idle, which the block does not
// enforce.
module frfcfs_dram_request_scheduler_top #(
    parameter int NUM_BANKS     = frs_pkg::NUM_BANKS_DEF,
    parameter int READ_ENTRIES  = frs_pkg::READ_ENTRIES_DEF,
    parameter int WRITE_ENTRIES = frs_pkg::WRITE_ENTRIES_DEF,
    parameter int ROW_BITS      = frs_pkg::ROW_BITS_DEF,
    parameter int TAG_BITS      = frs_pkg::TAG_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    frs_req_if.sink  req,
    frs_rsp_if.source rsp,
    frs_cfg_if.sink  cfg
);
    localparam int BW   = frs_pkg::BANK_W;
    localparam int RIW  = $clog2(READ_ENTRIES);
    localparam int WIW  = $clog2(WRITE_ENTRIES);
    localparam int MAXE = (READ_ENTRIES > WRITE_ENTRIES) ? READ_ENTRIES : WRITE_ENTRIES;
    localparam int SW   = $clog2(MAXE);
    localparam int OW   = SW;
    localparam int CW   = $clog2(MAXE + 1);
    localparam int KW   = (CW > frs_pkg::CFG_DATA_W) ? CW : frs_pkg::CFG_DATA_W;
    localparam int AW   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int DW   = BW + ROW_BITS + TAG_BITS + 1 + OW;
    localparam logic [SW-1:0] READ_LAST  = SW'(READ_ENTRIES - 1);
    localparam logic [SW-1:0] WRITE_LAST = SW'(WRITE_ENTRIES - 1);

    frs_pkg::state_t state_reg, state_next;
    frs_pkg::pass_t  pass_reg, pass_next;

    logic                cmd_reg, wr_reg;
    logic [BW-1:0]       bank_reg;
    logic [ROW_BITS-1:0] row_reg, open_row_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic                             sep_reg;
    logic [frs_pkg::CFG_DATA_W-1:0]   hiwm_reg, lowm_reg, rlim_reg, wlim_reg;

    logic          mode_reg, mode_next;
    logic [CW-1:0] rcnt_reg, rcnt_next, wcnt_reg, wcnt_next;

    logic                ract_vld_reg [NUM_BANKS];
    logic [ROW_BITS-1:0] ract_row_reg [NUM_BANKS];
    logic                wact_vld_reg [NUM_BANKS];
    logic [ROW_BITS-1:0] wact_row_reg [NUM_BANKS];

    logic          pool_reg, pool_next;
    logic [SW-1:0] scan_idx_reg, scan_idx_next, q_idx_reg, q_idx_next;
    logic          issue_reg, issue_next, q_vld_reg, q_vld_next;

    logic                any_reg, any_next, ohit_reg, ohit_next;
    logic                found_reg, found_next, match2_reg, match2_next;
    logic [OW-1:0]       best_ord_reg, best_ord_next;
    logic [ROW_BITS-1:0] best_row_reg, best_row_next, act_row_reg, act_row_next;
    logic [SW-1:0]       best_idx_reg, best_idx_next;
    logic [TAG_BITS-1:0] best_tag_reg, best_tag_next;
    logic                best_wr_reg, best_wr_next;
    logic                hit_reg, hit_next, granted_reg, granted_next;
    frs_pkg::status_t    status_reg, status_next;

    logic                o_vld_reg, o_vld_next;
    logic                o_granted_reg, o_granted_next, o_wr_reg, o_wr_next;
    logic                o_hit_reg, o_hit_next;
    logic [TAG_BITS-1:0] o_tag_reg, o_tag_next;
    logic [ROW_BITS-1:0] o_row_reg, o_row_next;
    frs_pkg::status_t    o_status_reg, o_status_next;
    logic [frs_pkg::PEND_W-1:0] o_rpend_reg, o_rpend_next, o_wpend_reg, o_wpend_next;
    logic                o_mode_reg, o_mode_next;

    // pool ports
    logic [DW-1:0]  r_rd_data, w_rd_data, wr_data;
    logic           r_rd_valid, w_rd_valid, r_free_found, w_free_found;
    logic [RIW-1:0] r_free_idx;
    logic [WIW-1:0] w_free_idx;
    logic           r_wr_en, w_wr_en, r_set, w_set, r_clr, w_clr;
    logic [SW-1:0]  wr_addr, valid_addr;

    logic                act_we, act_pool, act_vld_w;
    logic [ROW_BITS-1:0] act_row_w;

    logic [DW-1:0]       ent;
    logic                ent_v, ent_match;
    logic [BW-1:0]       ent_bank;
    logic [ROW_BITS-1:0] ent_row;
    logic [TAG_BITS-1:0] ent_tag;
    logic                ent_wr;
    logic [OW-1:0]       ent_ord;
    logic [AW-1:0]       bank_idx;
    logic                bank_ok, to_wpool, mode_new, free_ok, cur_vld;
    logic [KW-1:0]       cap, cnt_ext;
    logic [ROW_BITS-1:0] cur_row, new_row;
    logic [SW-1:0]       last_idx;

    frs_pool #(.ENTRIES(READ_ENTRIES), .DATA_W(DW)) u_read_pool (
        .clk(clk), .rst_n(rst_n),
        .rd_addr(scan_idx_reg[RIW-1:0]), .rd_data(r_rd_data), .rd_valid(r_rd_valid),
        .wr_en(r_wr_en), .wr_addr(wr_addr[RIW-1:0]), .wr_data(wr_data),
        .set_en(r_set), .clr_en(r_clr), .valid_addr(valid_addr[RIW-1:0]),
        .free_found(r_free_found), .free_idx(r_free_idx)
    );

    frs_pool #(.ENTRIES(WRITE_ENTRIES), .DATA_W(DW)) u_write_pool (
        .clk(clk), .rst_n(rst_n),
        .rd_addr(scan_idx_reg[WIW-1:0]), .rd_data(w_rd_data), .rd_valid(w_rd_valid),
        .wr_en(w_wr_en), .wr_addr(wr_addr[WIW-1:0]), .wr_data(wr_data),
        .set_en(w_set), .clr_en(w_clr), .valid_addr(valid_addr[WIW-1:0]),
        .free_found(w_free_found), .free_idx(w_free_idx)
    );

    assign ent      = pool_reg ? w_rd_data : r_rd_data;
    assign ent_v    = pool_reg ? w_rd_valid : r_rd_valid;
    assign ent_bank = ent[DW-1 -: BW];
    assign ent_row  = ent[OW + TAG_BITS + 1 +: ROW_BITS];
    assign ent_tag  = ent[OW + 1 +: TAG_BITS];
    assign ent_wr   = ent[OW];
    assign ent_ord  = ent[OW-1:0];
    assign ent_match = q_vld_reg && ent_v && (ent_bank == bank_reg);
    assign bank_idx = AW'(bank_reg);
    assign bank_ok  = (32'(bank_reg) < NUM_BANKS);
    assign last_idx = pool_reg ? WRITE_LAST : READ_LAST;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == frs_pkg::ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        mode_next     = mode_reg;
        rcnt_next     = rcnt_reg;
        wcnt_next     = wcnt_reg;
        pool_next     = pool_reg;
        scan_idx_next = scan_idx_reg;
        issue_next    = issue_reg;
        q_vld_next    = q_vld_reg;
        q_idx_next    = q_idx_reg;
        any_next      = any_reg;
        ohit_next     = ohit_reg;
        found_next    = found_reg;
        match2_next   = match2_reg;
        best_ord_next = best_ord_reg;
        best_row_next = best_row_reg;
        best_idx_next = best_idx_reg;
        best_tag_next = best_tag_reg;
        best_wr_next  = best_wr_reg;
        act_row_next  = act_row_reg;
        hit_next      = hit_reg;
        granted_next  = granted_reg;
        status_next   = status_reg;
        o_vld_next     = o_vld_reg && !rsp.ready;
        o_granted_next = o_granted_reg;
        o_tag_next     = o_tag_reg;
        o_row_next     = o_row_reg;
        o_wr_next      = o_wr_reg;
        o_hit_next     = o_hit_reg;
        o_status_next  = o_status_reg;
        o_rpend_next   = o_rpend_reg;
        o_wpend_next   = o_wpend_reg;
        o_mode_next    = o_mode_reg;

        r_wr_en = 1'b0; w_wr_en = 1'b0;
        r_set = 1'b0; w_set = 1'b0; r_clr = 1'b0; w_clr = 1'b0;
        wr_addr    = q_idx_reg;
        valid_addr = best_idx_reg;
        wr_data    = {ent[DW-1:OW], ent_ord - OW'(1)};
        act_we = 1'b0; act_pool = pool_reg; act_vld_w = 1'b0; act_row_w = act_row_reg;

        to_wpool = sep_reg && wr_reg;
        cap      = to_wpool
                 ? ((KW'(wlim_reg) < KW'(WRITE_ENTRIES)) ? KW'(wlim_reg) : KW'(WRITE_ENTRIES))
                 : ((KW'(rlim_reg) < KW'(READ_ENTRIES)) ? KW'(rlim_reg) : KW'(READ_ENTRIES));
        cnt_ext  = to_wpool ? KW'(wcnt_reg) : KW'(rcnt_reg);
        free_ok  = to_wpool ? w_free_found : r_free_found;

        if (!sep_reg)
            mode_new = 1'b0;
        else if (!mode_reg && (KW'(wcnt_reg) >= KW'(hiwm_reg)))
            mode_new = 1'b1;
        else if (mode_reg && (KW'(wcnt_reg) < KW'(lowm_reg)))
            mode_new = 1'b0;
        else
            mode_new = mode_reg;

        cur_vld = mode_new ? wact_vld_reg[bank_idx] : ract_vld_reg[bank_idx];
        cur_row = mode_new ? wact_row_reg[bank_idx] : ract_row_reg[bank_idx];
        new_row = ohit_reg ? open_row_reg : best_row_reg;

        unique case (state_reg)
            frs_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = frs_pkg::ST_DECODE;
                end
            end
            frs_pkg::ST_DECODE:
            begin
                granted_next = 1'b0;
                hit_next     = 1'b1;
                if (cmd_reg == frs_pkg::CMD_ENQUEUE)
                begin
                    state_next = frs_pkg::ST_RESP;
                    if (bank_ok && (cnt_ext < cap) && free_ok)
                    begin
                        status_next = frs_pkg::STATUS_OK;
                        wr_data     = {bank_reg, row_reg, tag_reg, wr_reg, OW'(cnt_ext)};
                        if (to_wpool)
                        begin
                            wr_addr    = SW'(w_free_idx);
                            valid_addr = SW'(w_free_idx);
                            w_wr_en    = 1'b1;
                            w_set      = 1'b1;
                            wcnt_next  = wcnt_reg + CW'(1);
                        end
                        else
                        begin
                            wr_addr    = SW'(r_free_idx);
                            valid_addr = SW'(r_free_idx);
                            r_wr_en    = 1'b1;
                            r_set      = 1'b1;
                            rcnt_next  = rcnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        status_next = frs_pkg::STATUS_REJECT;
                    end
                end
                else
                begin
                    mode_next   = mode_new;
                    pool_next   = mode_new;
                    any_next    = 1'b0;
                    ohit_next   = 1'b0;
                    found_next  = 1'b0;
                    match2_next = 1'b0;
                    if (!bank_ok)
                    begin
                        status_next = frs_pkg::STATUS_EMPTY;
                        state_next  = frs_pkg::ST_RESP;
                    end
                    else
                    begin
                        pass_next     = cur_vld ? frs_pkg::PASS_FIND_OLDEST
                                                : frs_pkg::PASS_PICK_ROW;
                        act_row_next  = cur_row;
                        scan_idx_next = '0;
                        issue_next    = 1'b1;
                        q_vld_next    = 1'b0;
                        state_next    = frs_pkg::ST_SCAN;
                    end
                end
            end
            frs_pkg::ST_SCAN:
            begin
                q_vld_next = issue_reg;
                q_idx_next = scan_idx_reg;
                if (issue_reg)
                begin
                    if (scan_idx_reg == last_idx)
                        issue_next = 1'b0;
                    else
                        scan_idx_next = scan_idx_reg + SW'(1);
                end

                unique case (pass_reg)
                    frs_pkg::PASS_PICK_ROW:
                    begin
                        if (ent_match)
                        begin
                            any_next = 1'b1;
                            if (ent_row == open_row_reg)
                                ohit_next = 1'b1;
                            if (!found_reg || (ent_ord < best_ord_reg))
                            begin
                                found_next    = 1'b1;
                                best_ord_next = ent_ord;
                                best_row_next = ent_row;
                            end
                        end
                    end
                    frs_pkg::PASS_FIND_OLDEST:
                    begin
                        if (ent_match && (ent_row == act_row_reg))
                        begin
                            if (found_reg)
                                match2_next = 1'b1;
                            if (!found_reg || (ent_ord < best_ord_reg))
                            begin
                                found_next    = 1'b1;
                                best_ord_next = ent_ord;
                                best_idx_next = q_idx_reg;
                                best_tag_next = ent_tag;
                                best_row_next = ent_row;
                                best_wr_next  = ent_wr;
                            end
                        end
                    end
                    frs_pkg::PASS_REORDER:
                    begin
                        // close the age gap left by the granted entry
                        if (q_vld_reg && ent_v && (ent_ord > best_ord_reg))
                        begin
                            r_wr_en = !pool_reg;
                            w_wr_en = pool_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (!issue_reg && !q_vld_reg)
                begin
                    scan_idx_next = '0;
                    issue_next    = 1'b1;
                    unique case (pass_reg)
                        frs_pkg::PASS_PICK_ROW:
                        begin
                            if (!any_reg)
                            begin
                                status_next = frs_pkg::STATUS_EMPTY;
                                state_next  = frs_pkg::ST_RESP;
                            end
                            else
                            begin
                                hit_next     = ohit_reg;
                                act_row_next = new_row;
                                act_we       = 1'b1;
                                act_vld_w    = 1'b1;
                                act_row_w    = new_row;
                                found_next   = 1'b0;
                                match2_next  = 1'b0;
                                pass_next    = frs_pkg::PASS_FIND_OLDEST;
                            end
                        end
                        frs_pkg::PASS_FIND_OLDEST:
                        begin
                            if (!found_reg)
                            begin
                                act_we      = 1'b1;
                                status_next = frs_pkg::STATUS_EMPTY;
                                state_next  = frs_pkg::ST_RESP;
                            end
                            else
                            begin
                                granted_next = 1'b1;
                                status_next  = frs_pkg::STATUS_OK;
                                r_clr        = !pool_reg;
                                w_clr        = pool_reg;
                                if (pool_reg)
                                    wcnt_next = wcnt_reg - CW'(1);
                                else
                                    rcnt_next = rcnt_reg - CW'(1);
                                // drop the active row once its last request leaves
                                act_we    = !match2_reg;
                                act_vld_w = 1'b0;
                                pass_next = frs_pkg::PASS_REORDER;
                            end
                        end
                        default:
                        begin
                            state_next = frs_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            frs_pkg::ST_RESP:
            begin
                if (!o_vld_reg || rsp.ready)
                begin
                    o_vld_next     = 1'b1;
                    o_granted_next = granted_reg;
                    o_tag_next     = granted_reg ? best_tag_reg : '0;
                    o_row_next     = granted_reg ? best_row_reg : '0;
                    o_wr_next      = granted_reg && best_wr_reg;
                    o_hit_next     = granted_reg && hit_reg;
                    o_status_next  = status_reg;
                    // hold the counts of this item while the result waits
                    o_rpend_next   = frs_pkg::PEND_W'(rcnt_reg);
                    o_wpend_next   = frs_pkg::PEND_W'(wcnt_reg);
                    o_mode_next    = mode_reg;
                    state_next     = frs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= frs_pkg::ST_IDLE;
            pass_reg   <= frs_pkg::PASS_PICK_ROW;
            sep_reg    <= 1'b0;
            hiwm_reg   <= 7'd32;
            lowm_reg   <= 7'd16;
            rlim_reg   <= 7'd64;
            wlim_reg   <= 7'd64;
            mode_reg   <= 1'b0;
            rcnt_reg   <= '0;
            wcnt_reg   <= '0;
            issue_reg  <= 1'b0;
            q_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                ract_vld_reg[b] <= 1'b0;
                wact_vld_reg[b] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            mode_reg  <= mode_next;
            rcnt_reg  <= rcnt_next;
            wcnt_reg  <= wcnt_next;
            issue_reg <= issue_next;
            q_vld_reg <= q_vld_next;
            o_vld_reg <= o_vld_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    frs_pkg::CFG_WRITE_SEPARATE: sep_reg  <= cfg.data[0];
                    frs_pkg::CFG_HIGH_WATERMARK: hiwm_reg <= cfg.data;
                    frs_pkg::CFG_LOW_WATERMARK:  lowm_reg <= cfg.data;
                    frs_pkg::CFG_READ_LIMIT:     rlim_reg <= cfg.data;
                    frs_pkg::CFG_WRITE_LIMIT:    wlim_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (act_we)
            begin
                if (act_pool)
                    wact_vld_reg[bank_idx] <= act_vld_w;
                else
                    ract_vld_reg[bank_idx] <= act_vld_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg      <= req.cmd;
            bank_reg     <= req.bank;
            row_reg      <= req.row;
            wr_reg       <= req.wr_req;
            tag_reg      <= req.req_tag;
            open_row_reg <= req.open_row;
        end
        if (act_we && act_vld_w)
        begin
            if (act_pool)
                wact_row_reg[bank_idx] <= act_row_w;
            else
                ract_row_reg[bank_idx] <= act_row_w;
        end
        pool_reg      <= pool_next;
        scan_idx_reg  <= scan_idx_next;
        q_idx_reg     <= q_idx_next;
        any_reg       <= any_next;
        ohit_reg      <= ohit_next;
        found_reg     <= found_next;
        match2_reg    <= match2_next;
        best_ord_reg  <= best_ord_next;
        best_row_reg  <= best_row_next;
        best_idx_reg  <= best_idx_next;
        best_tag_reg  <= best_tag_next;
        best_wr_reg   <= best_wr_next;
        act_row_reg   <= act_row_next;
        hit_reg       <= hit_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        o_granted_reg <= o_granted_next;
        o_tag_reg     <= o_tag_next;
        o_row_reg     <= o_row_next;
        o_wr_reg      <= o_wr_next;
        o_hit_reg     <= o_hit_next;
        o_status_reg  <= o_status_next;
        o_rpend_reg   <= o_rpend_next;
        o_wpend_reg   <= o_wpend_next;
        o_mode_reg    <= o_mode_next;
    end

    assign rsp.valid          = o_vld_reg;
    assign rsp.granted        = o_granted_reg;
    assign rsp.grant_tag      = o_tag_reg;
    assign rsp.grant_row      = o_row_reg;
    assign rsp.grant_wr       = o_wr_reg;
    assign rsp.row_hit        = o_hit_reg;
    assign rsp.status         = o_status_reg;
    assign rsp.reads_pending  = o_rpend_reg;
    assign rsp.writes_pending = o_wpend_reg;
    assign rsp.wr_drain       = o_mode_reg;
endmodule
`default_nettype wire
